// ----- sv/qpe_pkg.sv -----
package qpe_pkg;

	// Default size of the value buffer, in raw bytes.
	localparam int VALUE_DEPTH_DEF = 64;

	// Longest key name that the matcher compares.
	localparam logic [3:0] KEY_BYTES = 4'd8;

	// Key position saturates here.
	localparam logic [3:0] KEY_POS_MAX = 4'd15;

	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ONE   = 8'h31;

	// Register map, indexed by address bit 3.
	localparam logic REG_TARGET_KEY = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	// Returns {is_hex, nibble}.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ----- sv/qpe_ram.sv -----
module qpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/query_parameter_extractor.sv -----
// Scans a URL query string one byte per request and returns the value of the parameter
// whose name equals target_key (key_length bytes, first byte in bits 7..0). '?' restarts
// the parse, '&' closes a parameter and '=' starts or restarts its value. The value is
// percent-decoded ('+' is a space, '%' takes up to two hex digits) and delivered one byte
// per result with last_byte set on the final one; an empty value gives '1', and a string
// that ends without a match gives one result with found low. Raw value bytes sit in a
// VALUE_DEPTH-byte buffer; extra bytes are dropped and truncated is set. Delivering a
// value walks the buffer through its registered read port: fetch, look and output per
// byte, an escape also fetching and looking at each digit; out_stall holds the output.
// Not-found and empty-value results go straight to output. Input is stalled while results
// are being produced. Write registers only while the block is idle.
module query_parameter_extractor
	import qpe_pkg::*;
#(
	parameter int VALUE_DEPTH = VALUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_string,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic        found,
	output logic        truncated
);

	localparam int AW = $clog2(VALUE_DEPTH);
	localparam int CW = $clog2(VALUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(VALUE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_LOOK,
		S_OUT
	} state_t;

	state_t state_q;

	logic [63:0]   target_key_q;
	logic [3:0]    key_length_q;

	logic [3:0]    key_pos_q;
	logic          key_mis_q;
	logic          seen_eq_q;
	logic [CW-1:0] val_cnt_q;
	logic          val_ovf_q;
	logic          match_done_q;

	logic [CW-1:0] em_cnt_q;
	logic [CW-1:0] ptr_q;
	logic          pct_q;
	logic          digit_idx_q;
	logic          digits_ok_q;
	logic [7:0]    acc_q;

	// Next parse state after the current request, before the end-of-string clear.
	logic [3:0]    p_key_pos;
	logic          p_key_mis;
	logic          p_seen_eq;
	logic [CW-1:0] p_val_cnt;
	logic          p_val_ovf;
	logic          amp_hit;
	logic          end_test;
	logic          end_match;
	logic          wr_en;

	logic [3:0]    eff_len;
	logic [5:0]    key_sel;
	logic [7:0]    key_byte;
	logic          in_acc;
	logic          cfg_wr;

	logic [7:0]    rdata;
	logic [CW-1:0] nxt_ptr;
	logic          at_end;
	logic [4:0]    hv;
	logic          dig_ok;
	logic [7:0]    acc_n;

	qpe_ram #(
		.WIDTH (8),
		.DEPTH (VALUE_DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (val_cnt_q[AW-1:0]),
		.wdata (in_byte),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite;
	assign prdata    = (paddr[3] == REG_KEY_LENGTH) ? {60'd0, key_length_q} : target_key_q;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = (state_q == S_OUT);

	assign eff_len  = (key_length_q > KEY_BYTES) ? KEY_BYTES : key_length_q;
	assign key_sel  = {key_pos_q[2:0], 3'b000};
	assign key_byte = target_key_q[key_sel +: 8];

	assign nxt_ptr = ptr_q + CW'(1);
	assign at_end  = (nxt_ptr >= em_cnt_q);
	assign hv      = hex_decode(rdata);
	assign dig_ok  = digits_ok_q & hv[4];
	assign acc_n   = dig_ok ? {acc_q[3:0], hv[3:0]} : acc_q;

	always_comb begin
		p_key_pos = key_pos_q;
		p_key_mis = key_mis_q;
		p_seen_eq = seen_eq_q;
		p_val_cnt = val_cnt_q;
		p_val_ovf = val_ovf_q;
		amp_hit   = 1'b0;
		wr_en     = 1'b0;
		if (in_acc && !match_done_q) begin
			priority if (in_byte == CH_QUEST) begin
				p_key_pos = '0;
				p_key_mis = 1'b0;
				p_seen_eq = 1'b0;
				p_val_cnt = '0;
				p_val_ovf = 1'b0;
			end else if (in_byte == CH_AMP) begin
				amp_hit   = (key_pos_q != 4'd0) && !key_mis_q && (key_pos_q == eff_len);
				p_key_pos = '0;
				p_key_mis = 1'b0;
				p_seen_eq = 1'b0;
				p_val_cnt = '0;
				p_val_ovf = 1'b0;
			end else if (in_byte == CH_EQ) begin
				p_seen_eq = 1'b1;
				p_val_cnt = '0;
				p_val_ovf = 1'b0;
			end else if (seen_eq_q) begin
				if (val_cnt_q < DEPTH_C) begin
					wr_en     = 1'b1;
					p_val_cnt = val_cnt_q + CW'(1);
				end else begin
					p_val_ovf = 1'b1;
				end
			end else begin
				if (!key_mis_q) begin
					if (key_pos_q >= eff_len || key_byte != in_byte) begin
						p_key_mis = 1'b1;
					end
				end
				if (key_pos_q != KEY_POS_MAX) begin
					p_key_pos = key_pos_q + 4'd1;
				end
			end
		end
		end_test  = end_of_string && !match_done_q && !amp_hit;
		end_match = !p_key_mis && (p_key_pos == eff_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			target_key_q <= '0;
			key_length_q <= '0;
			key_pos_q    <= '0;
			key_mis_q    <= 1'b0;
			seen_eq_q    <= 1'b0;
			val_cnt_q    <= '0;
			val_ovf_q    <= 1'b0;
			match_done_q <= 1'b0;
			em_cnt_q     <= '0;
			ptr_q        <= '0;
			pct_q        <= 1'b0;
			digit_idx_q  <= 1'b0;
			digits_ok_q  <= 1'b0;
			acc_q        <= '0;
			out_byte     <= '0;
			last_byte    <= 1'b0;
			found        <= 1'b0;
			truncated    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3])
					REG_TARGET_KEY: target_key_q <= pwdata;
					REG_KEY_LENGTH: key_length_q <= pwdata[3:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (end_of_string) begin
							key_pos_q    <= '0;
							key_mis_q    <= 1'b0;
							seen_eq_q    <= 1'b0;
							val_cnt_q    <= '0;
							val_ovf_q    <= 1'b0;
							match_done_q <= 1'b0;
						end else begin
							key_pos_q    <= p_key_pos;
							key_mis_q    <= p_key_mis;
							seen_eq_q    <= p_seen_eq;
							val_cnt_q    <= p_val_cnt;
							val_ovf_q    <= p_val_ovf;
							match_done_q <= match_done_q | amp_hit;
						end

						if (amp_hit || (end_test && end_match)) begin
							// The '&' path reports the value as it stood before the clear.
							if (amp_hit) begin
								em_cnt_q <= val_cnt_q;
							end else begin
								em_cnt_q <= p_val_cnt;
							end
							ptr_q <= '0;
							pct_q <= 1'b0;
							found <= 1'b1;
							if ((amp_hit ? val_cnt_q : p_val_cnt) == '0) begin
								out_byte  <= CH_ONE;
								last_byte <= 1'b1;
								truncated <= amp_hit ? val_ovf_q : p_val_ovf;
								state_q   <= S_OUT;
							end else begin
								truncated <= amp_hit ? val_ovf_q : p_val_ovf;
								state_q   <= S_FETCH;
							end
						end else if (end_test) begin
							out_byte  <= '0;
							last_byte <= 1'b1;
							found     <= 1'b0;
							truncated <= 1'b0;
							state_q   <= S_OUT;
						end
					end
				end

				S_FETCH: begin
					state_q <= S_LOOK;
				end

				S_LOOK: begin
					ptr_q <= nxt_ptr;
					if (!pct_q) begin
						if (rdata == CH_PCT && !at_end) begin
							pct_q       <= 1'b1;
							digit_idx_q <= 1'b0;
							digits_ok_q <= 1'b1;
							acc_q       <= '0;
							state_q     <= S_FETCH;
						end else begin
							priority if (rdata == CH_PCT) begin
								out_byte <= '0;
							end else if (rdata == CH_PLUS) begin
								out_byte <= CH_SPACE;
							end else begin
								out_byte <= rdata;
							end
							last_byte <= at_end;
							state_q   <= S_OUT;
						end
					end else begin
						acc_q       <= acc_n;
						digits_ok_q <= dig_ok;
						if (digit_idx_q || at_end) begin
							out_byte  <= acc_n;
							last_byte <= at_end;
							pct_q     <= 1'b0;
							state_q   <= S_OUT;
						end else begin
							digit_idx_q <= 1'b1;
							state_q     <= S_FETCH;
						end
					end
				end

				S_OUT: begin
					if (!out_stall) begin
						state_q <= last_byte ? S_IDLE : S_FETCH;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- bench/query_parameter_extractor_test.sv -----
`timescale 1ns / 100ps

module query_parameter_extractor_test;
	import qpe_pkg::*;

	localparam logic [3:0] ADDR_TARGET_KEY = {REG_TARGET_KEY, 3'b000};
	localparam logic [3:0] ADDR_KEY_LENGTH = {REG_KEY_LENGTH, 3'b000};
	localparam int DRAIN_CYCLES = 40;
	localparam string HEX_CHARS = "0123456789abcdefABCDEF";

	typedef logic [7:0] char_q_t [$];

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       hit;
		logic       cut;
	} value_byte_t;

	class param_value_predictor;
		logic [63:0] key;
		logic [3:0]  key_len;
		logic [3:0]  name_pos;
		bit          name_bad;
		bit          in_value;
		logic [7:0]  raw_value [VALUE_DEPTH_DEF];
		int          raw_count;
		bit          raw_cut;
		bit          answered;
		value_byte_t value_bytes [$];
		int          failures;
		int          checked;
		int          values_found;
		int          values_missing;
		int          values_cut;

		function new();
			key = '0;
			key_len = '0;
			answered = 0;
			failures = 0;
			checked = 0;
			values_found = 0;
			values_missing = 0;
			values_cut = 0;
			clear_param();
		endfunction

		function void clear_param();
			name_pos = '0;
			name_bad = 0;
			in_value = 0;
			raw_count = 0;
			raw_cut = 0;
		endfunction

		function logic [3:0] name_len();
			return (key_len > KEY_BYTES) ? KEY_BYTES : key_len;
		endfunction

		function bit name_hit();
			return !name_bad && name_pos == name_len();
		endfunction

		function int waiting();
			return value_bytes.size();
		endfunction

		// Single decoding pass over the raw value bytes.
		function void push_value();
			int i;
			int j;
			int k;
			logic [7:0] c;
			logic [7:0] d;
			logic [7:0] v;
			logic [3:0] nib;
			bit digits;
			bit is_hex;
			if (raw_count == 0) begin
				value_bytes.push_back('{CH_ONE, 1'b0, 1'b1, raw_cut});
			end else begin
				i = 0;
				while (i < raw_count) begin
					c = raw_value[i];
					if (c == CH_PLUS) begin
						c = CH_SPACE;
						i++;
					end else if (c == CH_PCT) begin
						v = '0;
						digits = 1;
						j = i + 1;
						for (k = 0; k < 2 && j < raw_count; k++) begin
							d = raw_value[j];
							is_hex = 1;
							nib = '0;
							if (d >= "0" && d <= "9") begin
								nib = 4'(d - "0");
							end else if (d >= "a" && d <= "f") begin
								nib = 4'(d - "a" + 8'd10);
							end else if (d >= "A" && d <= "F") begin
								nib = 4'(d - "A" + 8'd10);
							end else begin
								is_hex = 0;
							end
							if (!is_hex)
								digits = 0;
							if (digits)
								v = {v[3:0], nib};
							j++;
						end
						c = v;
						i = j;
					end else begin
						i++;
					end
					value_bytes.push_back('{c, 1'b0, 1'b1, raw_cut});
				end
			end
			value_bytes[value_bytes.size() - 1].last = 1'b1;
			values_found++;
			if (raw_cut)
				values_cut++;
		endfunction

		function void take_char(logic [7:0] b, bit eos);
			if (!answered) begin
				if (b == CH_QUEST) begin
					clear_param();
				end else if (b == CH_AMP) begin
					if (name_pos != 0 && name_hit()) begin
						push_value();
						answered = 1;
					end
					clear_param();
				end else if (b == CH_EQ) begin
					in_value = 1;
					raw_count = 0;
					raw_cut = 0;
				end else if (in_value) begin
					if (raw_count < VALUE_DEPTH_DEF) begin
						raw_value[raw_count] = b;
						raw_count++;
					end else begin
						raw_cut = 1;
					end
				end else begin
					if (!name_bad) begin
						if (name_pos >= name_len())
							name_bad = 1;
						else if (key[8 * name_pos +: 8] != b)
							name_bad = 1;
					end
					if (name_pos < KEY_POS_MAX)
						name_pos++;
				end
				if (eos && !answered) begin
					if (name_hit()) begin
						push_value();
					end else begin
						value_bytes.push_back('{8'h00, 1'b1, 1'b0, 1'b0});
						values_missing++;
					end
				end
			end
			if (eos) begin
				clear_param();
				answered = 0;
			end
		endfunction

		function void check_result(logic [7:0] data, logic last, logic hit, logic cut);
			value_byte_t want;
			checked++;
			if (value_bytes.size() == 0) begin
				$error("result with nothing expected: out_byte %02h", data);
				failures++;
				return;
			end
			want = value_bytes.pop_front();
			if (data !== want.data) begin
				$error("out_byte: expected %02h, got %02h", want.data, data);
				failures++;
			end
			if (last !== want.last) begin
				$error("last_byte: expected %0b, got %0b", want.last, last);
				failures++;
			end
			if (hit !== want.hit) begin
				$error("found: expected %0b, got %0b", want.hit, hit);
				failures++;
			end
			if (cut !== want.cut) begin
				$error("truncated: expected %0b, got %0b", want.cut, cut);
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        end_of_string;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        last_byte;
	logic        found;
	logic        truncated;

	param_value_predictor sb = new();

	logic [63:0] cur_key;
	logic [3:0]  cur_len;
	int          burst_left = 0;
	int          chars_sent = 0;
	int          strings_sent = 0;
	int          settings = 0;

	query_parameter_extractor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_byte    (last_byte),
		.found        (found),
		.truncated    (truncated)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [7:0] random_letter();
		return 8'($urandom_range(8'h61, 8'h7a));
	endfunction

	function automatic logic [63:0] letter_key();
		logic [63:0] k;
		for (int i = 0; i < 8; i++)
			k[8 * i +: 8] = random_letter();
		return k;
	endfunction

	function automatic char_q_t chars_of(input string text);
		char_q_t s;
		for (int i = 0; i < text.len(); i++)
			s.push_back(text[i]);
		return s;
	endfunction

	// Mostly well-formed queries built around the current key, some noise.
	function automatic char_q_t random_query();
		char_q_t s;
		int nparams;
		int n;
		int k;
		int eff;
		eff = (cur_len > KEY_BYTES) ? KEY_BYTES : cur_len;
		if ($urandom_range(0, 99) < 12) begin
			n = $urandom_range(1, 12);
			repeat (n) s.push_back(8'($urandom_range(0, 255)));
			return s;
		end
		if ($urandom_range(0, 1))
			s.push_back(CH_QUEST);
		nparams = $urandom_range(1, 4);
		for (int p = 0; p < nparams; p++) begin
			if (p != 0)
				s.push_back(CH_AMP);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					for (k = 0; k < eff; k++)
						s.push_back(cur_key[8 * k +: 8]);
				end
				5, 6: begin
					// Near miss: the key cut short, extended or with one byte altered.
					for (k = 0; k < eff; k++)
						s.push_back(cur_key[8 * k +: 8]);
					case ($urandom_range(0, 2))
						0: if (eff > 0) void'(s.pop_back());
						1: s.push_back(random_letter());
						default: if (eff > 0) s[s.size() - 1] = s[s.size() - 1] ^ 8'h01;
					endcase
				end
				default: begin
					n = $urandom_range(0, 6);
					repeat (n) s.push_back(random_letter());
				end
			endcase
			if ($urandom_range(0, 9) != 0) begin
				s.push_back(CH_EQ);
				n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
				repeat (n) begin
					case ($urandom_range(0, 19))
						0, 1, 2: s.push_back(CH_PLUS);
						3, 4, 5, 6: s.push_back(CH_PCT);
						7, 8, 9, 10, 11: s.push_back(HEX_CHARS[$urandom_range(0, 21)]);
						12: s.push_back(CH_EQ);
						13, 14: s.push_back(8'($urandom_range(0, 255)));
						default: s.push_back(random_letter());
					endcase
				end
			end
		end
		if (s.size() == 0)
			s.push_back(random_letter());
		return s;
	endfunction

	task automatic send_char(input logic [7:0] b, input bit eos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_string <= eos;
		do @(posedge clk); while (in_stall);
		sb.take_char(b, eos);
		chars_sent++;
	endtask

	task automatic send_chars(input char_q_t s);
		for (int i = 0; i < s.size(); i++)
			send_char(s[i], i == s.size() - 1);
		strings_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.waiting() != 0);
	endtask

	task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_TARGET_KEY)
			sb.key = data;
		else if (addr == ADDR_KEY_LENGTH)
			sb.key_len = data[3:0];
		@(posedge clk);
	endtask

	task automatic configure(input logic [63:0] key, input logic [3:0] len);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		reg_write(ADDR_TARGET_KEY, key);
		reg_write(ADDR_KEY_LENGTH, 64'(len));
		cur_key = key;
		cur_len = len;
		settings++;
	endtask

	// Receiver: checks accepted results and stalls on its own pattern.
	initial begin
		int window_left;
		int mode;
		int hold_left;
		int next_hold;
		out_stall <= 1'b0;
		window_left = 0;
		mode = 0;
		hold_left = 0;
		next_hold = 30;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				sb.check_result(out_byte, last_byte, found, truncated);
			// A long hold-off lets the block back up into its input.
			if (sb.checked == next_hold) begin
				hold_left = 400;
				next_hold += 100;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (window_left == 0) begin
					mode = $urandom_range(0, 3);
					window_left = $urandom_range(20, 80);
				end
				window_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= ((window_left % 4) < 2);
				endcase
			end
		end
	end

	initial begin
		#500000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		char_q_t s;
		int phase_chars;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		in_byte <= '0;
		end_of_string <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Restart, value restart, plus and both escape lengths, match on the
		// ampersand, then ignored input after the match.
		configure(64'h6b, 4'd1);
		send_chars(chars_of("x?k=z=a+%41%4&q"));
		// An escape whose first digit is not hex gives zero and eats both bytes.
		send_chars(chars_of("k=%g1"));
		// A name with no value gives the one character.
		send_chars(chars_of("k"));
		// Empty key: no match at the ampersand, a match at the end.
		configure(64'h0, 4'd0);
		send_chars(chars_of("&=v"));
		send_chars(chars_of("a"));

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: configure('1, 4'd15);
				1: configure({$urandom, $urandom}, KEY_BYTES);
				2: configure(letter_key(), 4'($urandom_range(1, 7)));
				3: configure('0, 4'd0);
				default: configure(letter_key(), 4'($urandom_range(0, 15)));
			endcase
			phase_chars = 0;
			while (phase_chars < 10) begin
				s = random_query();
				phase_chars += s.size();
				send_chars(s);
				if ($urandom_range(0, 5) == 0)
					wait_drained();
			end
		end

		in_valid <= 1'b0;
		for (int w = 0; w < 20000 && sb.waiting() != 0; w++)
			@(posedge clk);
		if (sb.waiting() != 0) begin
			$error("%0d expected result bytes never arrived", sb.waiting());
			sb.failures++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters in %0d query strings under %0d key settings.",
			chars_sent, strings_sent, settings);
		$display("Checked %0d result bytes: %0d values (%0d truncated), %0d not found.",
			sb.checked, sb.values_found, sb.values_cut, sb.values_missing);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
sv/qpe_pkg.sv
sv/qpe_ram.sv
sv/query_parameter_extractor.sv
bench/query_parameter_extractor_test.sv
